// File: hdl/sampling_profile_histogram_unit_macros.svh
// Assertion macros for the profile histogram checker.
`ifndef SAMPLING_PROFILE_HISTOGRAM_UNIT_MACROS_SVH
`define SAMPLING_PROFILE_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram check failed");

// Next-cycle implication, off during reset.
`define SHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram check failed");

// Next-cycle implication that also holds across reset.
`define SHP_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("histogram check failed");

`endif

// File: hdl/shp_pkg.sv
// Shared types and constants of the sampling profile histogram.
package shp_pkg;

  localparam int BUCKETS_DEFAULT = 1024;
  localparam int SHIFT_MAX       = 31;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic               code_saved;
    logic               lib_space;
    logic signed [31:0] run_line;
    logic [30:0]        top_line;
    logic [9:0]         bucket_index;
  } item_t;

  typedef struct packed {
    logic [31:0] hit_count;
    logic [31:0] other_total;
    logic [31:0] library_total;
    logic [4:0]  shift_now;
    logic        out_of_range;
  } result_t;

endpackage

// File: hdl/shp_store.sv
// Bucket counter memory: one write port, one registered read port.
module shp_store #(
  parameter int DEPTH = shp_pkg::BUCKETS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/shp_shift.sv
// Bucket shift search: smallest s with (BUCKETS << s) >= last line, capped at 31.
module shp_shift #(
  parameter int BUCKETS = shp_pkg::BUCKETS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] top_line,
  output logic        searching,
  output logic [4:0]  shift
);

  localparam int SW = $clog2(BUCKETS + 1) + shp_pkg::SHIFT_MAX + 1;

  logic [SW-1:0] span;
  logic [30:0]   last_r;
  logic          found;

  // 2^s >= ceil(last / BUCKETS) exactly when BUCKETS * 2^s >= last
  assign found = (span >= SW'(last_r)) || (shift == 5'(shp_pkg::SHIFT_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      searching <= 1'b0;
    end else if (start) begin
      searching <= 1'b1;
    end else if (searching && found) begin
      searching <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      span   <= SW'(BUCKETS);
      shift  <= '0;
      last_r <= top_line;
    end else if (searching && !found) begin
      span  <= span << 1;
      shift <= shift + 5'd1;
    end
  end

endmodule

// File: hdl/sampling_profile_histogram_unit.sv
// Sampling profile histogram: top level with command sequencing.
//
// Raise start with an item while busy is low; the item is taken at that edge.
// A tick or a read: the bucket memory is read in the accept cycle and
// written back in the next cycle, and the result shows on result for one
// cycle with strobe high right after. A kind 3 item, or a tick or clear while
// code_saved is low, goes through the same steps and changes nothing. A clear
// holds busy until the one-entry-per-cycle sweep of the bucket memory and the
// shift search that runs beside it have both finished. After reset, busy
// stays high while the memory is zeroed; that pass gives no result. Every
// item gives exactly one strobe beat, which the receiver must take.
module sampling_profile_histogram_unit #(
  parameter int BUCKETS = shp_pkg::BUCKETS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  shp_pkg::item_t   item,
  output logic             strobe,
  output shp_pkg::result_t result
);

  localparam int AW = $clog2(BUCKETS);

  shp_pkg::state_t state;
  logic            accept;

  logic [31:0] other_count;
  logic [31:0] library_count;
  logic [4:0]  bucket_shift;

  logic [AW-1:0] sweep_addr;
  logic          report;

  logic          op_inc;
  logic          op_read;
  logic          op_oor;
  logic [AW-1:0] op_addr;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic          shift_searching;
  logic [4:0]    shift_found;

  // Decode of the offered item
  logic        is_tick;
  logic        is_clear;
  logic        is_read;
  logic        counted;
  logic        line_none;
  logic [30:0] bucket;
  logic        bucket_bad;
  logic [31:0] idx_ext;
  logic        read_ok;
  logic        sweep_last;

  assign busy   = (state != shp_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign is_tick    = (item.kind == shp_pkg::KIND_TICK);
  assign is_clear   = (item.kind == shp_pkg::KIND_CLEAR) && item.code_saved;
  assign is_read    = (item.kind == shp_pkg::KIND_READ);
  assign counted    = is_tick && item.code_saved;
  assign line_none  = (item.run_line == -32'sd1);
  assign bucket     = item.run_line[30:0] >> bucket_shift;
  assign bucket_bad = item.run_line[31] || ({1'b0, bucket} >= 32'(BUCKETS));
  assign idx_ext    = 32'(item.bucket_index);
  assign read_ok    = is_read && (idx_ext < 32'(BUCKETS));
  assign raddr      = is_read ? idx_ext[AW-1:0] : bucket[AW-1:0];
  assign sweep_last = (sweep_addr == AW'(BUCKETS - 1));

  always_comb begin
    we    = 1'b0;
    waddr = op_addr;
    wdata = rdata + 32'd1;
    unique case (state)
      shp_pkg::ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = '0;
      end
      shp_pkg::ST_EXEC: begin
        we = op_inc;
      end
      shp_pkg::ST_IDLE: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  shp_store #(
    .DEPTH (BUCKETS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  shp_shift #(
    .BUCKETS (BUCKETS)
  ) u_shift (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && is_clear),
    .top_line  (item.top_line),
    .searching (shift_searching),
    .shift     (shift_found)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= shp_pkg::ST_SWEEP;
      sweep_addr    <= '0;
      report        <= 1'b0;
      strobe        <= 1'b0;
      other_count   <= '0;
      library_count <= '0;
      bucket_shift  <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        shp_pkg::ST_IDLE: begin
          if (accept) begin
            if (is_clear) begin
              state         <= shp_pkg::ST_SWEEP;
              sweep_addr    <= '0;
              report        <= 1'b1;
              other_count   <= '0;
              library_count <= '0;
            end else begin
              state <= shp_pkg::ST_EXEC;
              if (counted && item.lib_space) begin
                library_count <= library_count + 32'd1;
              end
              if (counted && !item.lib_space && line_none) begin
                other_count <= other_count + 32'd1;
              end
            end
          end
        end
        shp_pkg::ST_EXEC: begin
          state  <= shp_pkg::ST_IDLE;
          strobe <= 1'b1;
        end
        shp_pkg::ST_SWEEP: begin
          if (!sweep_last) begin
            sweep_addr <= sweep_addr + AW'(1);
          end else if (!shift_searching) begin
            state  <= shp_pkg::ST_IDLE;
            strobe <= report;
            report <= 1'b0;
            if (report) begin
              bucket_shift <= shift_found;
            end
          end
        end
        default: begin
          state <= shp_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Item payload held for the write-back cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_inc  <= counted && !item.lib_space && !line_none && !bucket_bad;
      op_oor  <= counted && !item.lib_space && !line_none && bucket_bad;
      op_read <= read_ok;
      op_addr <= raddr;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (state == shp_pkg::ST_EXEC) begin
      result.hit_count     <= op_read ? rdata : 32'd0;
      result.other_total   <= other_count;
      result.library_total <= library_count;
      result.shift_now     <= bucket_shift;
      result.out_of_range  <= op_oor;
    end else if (state == shp_pkg::ST_SWEEP) begin
      result.hit_count     <= '0;
      result.other_total   <= other_count;
      result.library_total <= library_count;
      result.shift_now     <= shift_found;
      result.out_of_range  <= 1'b0;
    end
  end

endmodule

// File: hdl/shp_chk.sv
// Port-level checker for the sampling profile histogram, bound to the top level.
`include "sampling_profile_histogram_unit_macros.svh"

module shp_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input shp_pkg::item_t   item,
  input logic             strobe,
  input shp_pkg::result_t result
);

  // Reset always starts the clearing pass
  `SHP_ASSERT_ALWAYS(a_reset_sweep, rst, busy)
  // An accepted item occupies the block in the next cycle
  `SHP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result beat appears only once the block is free again
  `SHP_ASSERT_NOW(a_strobe_idle, strobe, !busy)
  // One beat per item: beats never come back to back
  `SHP_ASSERT_NEXT(a_strobe_single, strobe, !strobe)
  // A dropped tick never carries a bucket count
  `SHP_ASSERT_NOW(a_oor_no_hit, strobe && result.out_of_range, result.hit_count == 32'd0)

endmodule

bind sampling_profile_histogram_unit shp_chk u_shp_chk (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the sampling profile histogram unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int          NUM_BUCKETS  = shp_pkg::BUCKETS_DEFAULT;
  localparam int          RANDOM_ITEMS = 680;
  localparam int          TAIL_CYCLES  = 16;
  localparam int          MAX_PRINTS   = 60;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  typedef struct {
    shp_pkg::item_t it;
    int unsigned    gap;
    bit             settle;
  } sample_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  shp_pkg::item_t   item = '0;
  logic             busy;
  logic             strobe;
  shp_pkg::result_t result;

  sampling_profile_histogram_unit #(.BUCKETS(NUM_BUCKETS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // Shadow of the histogram state.
  logic [31:0] hist_model [NUM_BUCKETS];
  logic [31:0] other_model;
  logic [31:0] lib_model;
  logic [4:0]  shift_model;

  sample_beat_t     sample_queue [$];
  shp_pkg::result_t predicted_readouts [$];

  int unsigned accepted_total = 0;
  int unsigned readout_total  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  int unsigned bucket_hits  = 0;
  int unsigned drop_hits    = 0;
  int unsigned other_hits   = 0;
  int unsigned lib_hits     = 0;
  int unsigned clears_done  = 0;
  int unsigned reads_done   = 0;
  int unsigned reads_filled = 0;

  function automatic logic [4:0] span_shift(logic [30:0] last);
    longint unsigned per_bucket;
    int              s;
    per_bucket = (longint'(last) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    s = 0;
    while (s < shp_pkg::SHIFT_MAX && (64'd1 << s) < per_bucket) s++;
    return s[4:0];
  endfunction

  function automatic shp_pkg::result_t profile_step(shp_pkg::item_t it);
    shp_pkg::result_t r;
    logic [31:0]      b;
    r = '0;
    case (it.kind)
      shp_pkg::KIND_TICK: begin
        if (it.code_saved) begin
          if (it.lib_space) begin
            lib_model = lib_model + 32'd1;
            lib_hits++;
          end else if (it.run_line == -32'sd1) begin
            other_model = other_model + 32'd1;
            other_hits++;
          end else if (it.run_line[31]) begin
            r.out_of_range = 1'b1;
            drop_hits++;
          end else begin
            b = unsigned'(it.run_line) >> shift_model;
            if (b >= NUM_BUCKETS) begin
              r.out_of_range = 1'b1;
              drop_hits++;
            end else begin
              hist_model[b] = hist_model[b] + 32'd1;
              bucket_hits++;
            end
          end
        end
      end
      shp_pkg::KIND_CLEAR: begin
        if (it.code_saved) begin
          foreach (hist_model[i]) hist_model[i] = '0;
          other_model = '0;
          lib_model   = '0;
          shift_model = span_shift(it.top_line);
          clears_done++;
        end
      end
      shp_pkg::KIND_READ: begin
        if (it.bucket_index < NUM_BUCKETS) r.hit_count = hist_model[it.bucket_index];
        reads_done++;
        if (r.hit_count != 0) reads_filled++;
      end
      default: ;
    endcase
    r.other_total   = other_model;
    r.library_total = lib_model;
    r.shift_now     = shift_model;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_sample(shp_pkg::kind_t k, bit saved, bit lib, logic [31:0] line,
                              logic [30:0] last, logic [9:0] idx,
                              int unsigned gap, bit settle);
    sample_beat_t sb;
    sb.it.kind         = k;
    sb.it.code_saved   = saved;
    sb.it.lib_space    = lib;
    sb.it.run_line     = line;
    sb.it.top_line     = last;
    sb.it.bucket_index = idx;
    sb.gap             = gap;
    sb.settle          = settle;
    sample_queue.push_back(sb);
  endtask

  function automatic int unsigned gap_for(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 12);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  // Driver: one beat per accepted start, paced by the gap drawn for each item.
  sample_beat_t cur_beat;
  bit           beat_loaded = 1'b0;
  bit           drive_go;
  int unsigned  hold_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      drive_go = start;
      if (start && !busy) begin
        predicted_readouts.push_back(profile_step(item));
        accepted_total++;
        drive_go    = 1'b0;
        beat_loaded = 1'b0;
      end
      if (!drive_go) begin
        if (!beat_loaded && sample_queue.size() != 0) begin
          cur_beat    = sample_queue.pop_front();
          hold_cycles = cur_beat.gap;
          beat_loaded = 1'b1;
        end
        if (beat_loaded) begin
          if (hold_cycles != 0) hold_cycles--;
          else if (!cur_beat.settle || accepted_total == readout_total) drive_go = 1'b1;
        end
      end
      start <= drive_go;
      if (drive_go) item <= cur_beat.it;
    end
  end

  // Monitor: every strobe beat is taken and checked against the oldest prediction.
  shp_pkg::result_t want;

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (predicted_readouts.size() == 0) begin
        report_mismatch("strobe with nothing pending", 32'd1, 32'd0);
      end else begin
        want = predicted_readouts.pop_front();
        if (result.hit_count !== want.hit_count)
          report_mismatch("hit_count", result.hit_count, want.hit_count);
        if (result.other_total !== want.other_total)
          report_mismatch("other_total", result.other_total, want.other_total);
        if (result.library_total !== want.library_total)
          report_mismatch("library_total", result.library_total, want.library_total);
        if (result.shift_now !== want.shift_now)
          report_mismatch("shift_now", 32'(result.shift_now), 32'(want.shift_now));
        if (result.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", 32'(result.out_of_range),
                          32'(want.out_of_range));
        readout_total <= readout_total + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  int unsigned      n;
  int               gap_mode;
  int unsigned      pick;
  int unsigned      focus_base;
  logic [4:0]       gen_shift;
  bit               settle_next;
  shp_pkg::kind_t   k;
  bit               saved;
  bit               lib;
  logic [31:0]      line;
  logic [30:0]      last;
  logic [9:0]       idx;
  shp_pkg::result_t stale;

  initial begin
    foreach (hist_model[i]) hist_model[i] = '0;
    other_model = '0;
    lib_model   = '0;
    shift_model = '0;

    // Directed: field extremes, each kind and the corner cases.
    queue_sample(shp_pkg::KIND_READ,  1, 0, 32'd0,         31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'd0,         31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'd1023,      31'd0,         10'd0,    2, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'd1024,      31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'hFFFF_FFFF, 31'd0,         10'd0,    1, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'h8000_0000, 31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'h7FFF_FFFF, 31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 1, 32'd5,         31'd0,         10'd0,    3, 0);
    // library wins even outside any line
    queue_sample(shp_pkg::KIND_TICK,  1, 1, 32'hFFFF_FFFF, 31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  0, 0, 32'd0,         31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_READ,  0, 0, 32'd0,         31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_READ,  1, 0, 32'd0,         31'd0,         10'd1023, 0, 1);
    queue_sample(shp_pkg::KIND_NOP,   1, 1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 10'd1023, 0, 0);
    queue_sample(shp_pkg::KIND_CLEAR, 0, 0, 32'd0,         31'd5000,      10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_READ,  1, 0, 32'd0,         31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_CLEAR, 1, 0, 32'd0,         31'd0,         10'd0,    4, 0);
    queue_sample(shp_pkg::KIND_READ,  1, 0, 32'd0,         31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_CLEAR, 1, 0, 32'd0,         31'h7FFF_FFFF, 10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'h7FFF_FFFF, 31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_READ,  1, 0, 32'd0,         31'd0,         10'd1023, 0, 0);
    queue_sample(shp_pkg::KIND_CLEAR, 1, 0, 32'd0,         31'd1025,      10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'd2047,      31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_TICK,  1, 0, 32'd2048,      31'd0,         10'd0,    0, 0);
    queue_sample(shp_pkg::KIND_READ,  1, 0, 32'd0,         31'd0,         10'd1023, 0, 0);
    queue_sample(shp_pkg::KIND_CLEAR, 1, 0, 32'd0,         31'd1024,      10'd0,    0, 0);
    gen_shift = 5'd0;

    // Random: mostly counted ticks and reads aimed at a small window of buckets.
    gap_mode    = 0;
    settle_next = 1'b0;
    focus_base  = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        gap_mode    = $urandom_range(0, 2);
        settle_next = ($urandom_range(0, 2) == 0);
        focus_base  = $urandom_range(0, NUM_BUCKETS - 16);
      end
      line  = $urandom;
      last  = 31'($urandom);
      idx   = 10'($urandom);
      saved = ($urandom_range(0, 9) != 0);
      lib   = ($urandom_range(0, 6) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 58) begin
        k = shp_pkg::KIND_TICK;
        case ($urandom_range(0, 19))
          0, 1:    line = 32'hFFFF_FFFF;
          2:       line = 32'h8000_0000 | $urandom;
          3:       line = $urandom;
          4:       line = (32'd1024 << gen_shift) | ($urandom & ((32'd1 << gen_shift) - 1));
          default: line = ((focus_base + $urandom_range(0, 15)) << gen_shift)
                          | ($urandom & ((32'd1 << gen_shift) - 1));
        endcase
      end else if (pick < 90) begin
        k = shp_pkg::KIND_READ;
        if ($urandom_range(0, 4) != 0) idx = 10'(focus_base + $urandom_range(0, 15));
      end else if (pick < 94) begin
        k = shp_pkg::KIND_CLEAR;
        saved = ($urandom_range(0, 6) != 0);
        case ($urandom_range(0, 3))
          0:       last = 31'd0;
          1:       last = 31'h7FFF_FFFF;
          2:       last = 31'((31'd1 << $urandom_range(10, 30)) + $urandom_range(0, 2) - 1);
          default: last = 31'($urandom);
        endcase
      end else if (pick < 97) begin
        k = shp_pkg::KIND_NOP;
      end else begin
        k = shp_pkg::kind_t'($urandom_range(0, 3));
      end
      if (k == shp_pkg::KIND_CLEAR && saved) begin
        gen_shift  = span_shift(last);
        focus_base = $urandom_range(0, NUM_BUCKETS - 16);
      end
      queue_sample(k, saved, lib, line, last, idx, gap_for(gap_mode), settle_next);
      settle_next = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    forever begin
      @(posedge clk);
      if (sample_queue.size() == 0 && !beat_loaded && !start &&
          readout_total == accepted_total) break;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    while (predicted_readouts.size() != 0) begin
      stale = predicted_readouts.pop_front();
      report_mismatch("result never seen, other_total", 32'd0, stale.other_total);
    end

    $display("covered %0d beats: %0d bucket hits, %0d dropped, %0d other, %0d library",
             accepted_total, bucket_hits, drop_hits, other_hits, lib_hits);
    $display("  %0d clears applied, %0d reads (%0d nonzero), %0d mismatches",
             clears_done, reads_done, reads_filled, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/shp_pkg.sv
hdl/shp_store.sv
hdl/shp_shift.sv
hdl/sampling_profile_histogram_unit.sv
hdl/shp_chk.sv
tb/tb_top.sv
